[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define RBM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define RBM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rbm_pkg.sv]
// shared types, codes and constants of the rom bank mapper
package rbm_pkg;

   // eeprom geometry
   localparam int EEPROM_BYTES = 128;
   localparam int ROM_AW       = $clog2(EEPROM_BYTES);
   localparam int ROM_ADDR_W   = 7;

   // input operations
   typedef enum logic [1:0] {
      OP_WRITE    = 2'd0,
      OP_READ     = 2'd1,
      OP_CYCLES   = 2'd2,
      OP_SCANLINE = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_READ   = 3'd0,
      KIND_CHR    = 3'd1,
      KIND_PRG16  = 3'd2,
      KIND_PRG8   = 3'd3,
      KIND_MIRROR = 3'd4,
      KIND_IRQ    = 3'd5,
      KIND_PASS   = 3'd6
   } kind_type;

   // mapper register numbers, addr[3:0]
   localparam logic [3:0] REG_CHR_FIRST = 4'd0;
   localparam logic [3:0] REG_CHR_LAST  = 4'd7;
   localparam logic [3:0] REG_PRG       = 4'd8;
   localparam logic [3:0] REG_MIRROR    = 4'd9;
   localparam logic [3:0] REG_IRQ_CTRL  = 4'd10;
   localparam logic [3:0] REG_IRQ_LO    = 4'd11;
   localparam logic [3:0] REG_IRQ_HI    = 4'd12;
   localparam logic [3:0] REG_EEPROM    = 4'd13;
   localparam logic [3:0] REG_ALT_LO_LAST = 4'd3;

   // csr register indexes
   localparam logic [1:0] CSR_ALT_MODE  = 2'd0;
   localparam logic [1:0] CSR_SCANLINE  = 2'd1;
   localparam logic [1:0] CSR_CHR_ROM   = 2'd2;

   // address map
   localparam logic [15:0] HIGH_REGION_BASE = 16'h8000;
   localparam logic [15:0] ALT_REG_END      = 16'h800C;

   // slots and values
   localparam logic [2:0] SLOT_NONE   = 3'd0;
   localparam logic [2:0] SLOT_PRG16  = 3'd4;
   localparam logic [2:0] SLOT_PRG8_0 = 3'd4;
   localparam logic [2:0] SLOT_PRG8_1 = 3'd5;
   localparam logic [2:0] SLOT_PRG8_2 = 3'd6;
   localparam logic [2:0] SLOT_PRG8_3 = 3'd7;
   localparam logic [9:0] READ_STATUS = 10'h010;
   localparam logic [9:0] ALT_HI_PAGE0 = 10'h01E;
   localparam logic [9:0] ALT_HI_PAGE1 = 10'h01F;
   localparam logic [7:0] SCANLINE_CYCLES = 8'd113;

   // eeprom line patterns on register 13
   localparam logic [7:0] EE_NONE  = 8'h00;
   localparam logic [7:0] EE_SCL   = 8'h20;
   localparam logic [7:0] EE_SDA   = 8'h40;
   localparam logic [7:0] EE_BOTH  = 8'h60;
   localparam logic [7:0] EE_RESET = 8'h80;
   localparam logic [7:0] EE_READ  = 8'hE0;
   localparam logic [7:0] EE_MASK_LAST = 8'h80;
   localparam logic [7:0] EE_MASK_FIRST = 8'h01;

   localparam int MAX_RESULTS = 4;

   // one result word
   typedef struct packed {
      kind_type   kind;
      logic [2:0] slot;
      logic [9:0] value;
   } result_type;

   // eeprom register write
   typedef struct packed {
      logic       wr_en;
      logic [7:0] data;
   } ee_cmd_type;

   // irq counter controls
   typedef struct packed {
      logic       ctrl_wr;
      logic       lo_wr;
      logic       hi_wr;
      logic [7:0] data;
      logic       tick;
      logic [7:0] amount;
   } irq_ctl_type;

endpackage

[hw/rtl/rbm_ram.sv]
// generic single-port-write ram with registered read
module rbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port, read returns old data on collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/rbm_eeprom.sv]
// serial eeprom emulation: pattern matcher, shift logic and byte store
module rbm_eeprom import rbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  ee_cmd_type cmd,
   output logic       status_bit
);

   logic                  status_ff, status_in;
   logic                  read_mode_ff, read_mode_in;
   logic [ROM_ADDR_W-1:0] address_ff, address_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            wmask_ff, wmask_in;
   logic [7:0]            rmask_ff, rmask_in;
   logic [7:0]            hist_ff [4];
   logic [7:0]            hist_in [4];
   logic [EEPROM_BYTES-1:0] valid_ff;
   logic                  fwd_valid_ff;
   logic [7:0]            fwd_data_ff;

   logic [7:0]        d;
   logic [7:0]        cur_byte;
   logic [7:0]        bit_byte;
   logic [7:0]        ram_rdata;
   logic              do_bit;
   logic              bit_one;
   logic              we;
   logic [ROM_AW-1:0] rd_idx;
   logic [ROM_AW-1:0] wr_addr;
   logic [ROM_AW-1:0] ram_raddr;

   assign d         = cmd.data;
   assign rd_idx    = ROM_AW'(address_ff);
   assign wr_addr   = ROM_AW'(address_ff);
   assign ram_raddr = ROM_AW'(address_in);

   // byte at the current address: never written reads zero, last write forwarded
   assign cur_byte = valid_ff[rd_idx] ? (fwd_valid_ff ? fwd_data_ff : ram_rdata) : 8'h00;

   // sequence match on the write history and the new word
   always_comb begin
      status_in    = status_ff;
      read_mode_in = read_mode_ff;
      address_in   = address_ff;
      shift_in     = shift_ff;
      wmask_in     = wmask_ff;
      rmask_in     = rmask_ff;
      hist_in      = hist_ff;
      we           = 1'b0;
      do_bit       = 1'b0;
      bit_one      = 1'b0;
      bit_byte     = shift_ff;
      if (cmd.wr_en) begin
         if (d == EE_RESET) begin
            address_in   = '0;
            read_mode_in = 1'b0;
            wmask_in     = '0;
            rmask_in     = '0;
         end else if (hist_ff[3] == EE_NONE && hist_ff[2] == EE_SCL && hist_ff[1] == EE_BOTH
                      && hist_ff[0] == EE_SDA && d == EE_NONE) begin
            // sync pattern, no effect
         end else if (hist_ff[3] == EE_NONE && hist_ff[2] == EE_SDA && hist_ff[1] == EE_BOTH
                      && hist_ff[0] == EE_SCL && d == EE_NONE) begin
            // start condition
            wmask_in     = EE_MASK_FIRST;
            rmask_in     = EE_MASK_FIRST;
            shift_in     = '0;
            read_mode_in = 1'b0;
         end else if (hist_ff[0] == EE_BOTH && d == EE_READ) begin
            if (!read_mode_ff) begin
               wmask_in     = EE_MASK_FIRST;
               rmask_in     = EE_MASK_FIRST;
               shift_in     = '0;
               read_mode_in = 1'b1;
               status_in    = 1'b0;
            end else begin
               shift_in  = cur_byte;
               status_in = |(cur_byte & rmask_ff);
               rmask_in  = rmask_ff << 1;
               wmask_in  = '0;
            end
         end else if (hist_ff[1] == EE_NONE && hist_ff[0] == EE_SCL && d == EE_NONE) begin
            do_bit = 1'b1;
         end else if (hist_ff[3] == EE_NONE && hist_ff[2] == EE_SDA && hist_ff[1] == EE_BOTH
                      && hist_ff[0] == EE_SDA && d == EE_NONE) begin
            do_bit  = 1'b1;
            bit_one = 1'b1;
         end
         hist_in[0] = d;
         hist_in[1] = hist_ff[0];
         hist_in[2] = hist_ff[1];
         hist_in[3] = hist_ff[2];
      end
      // clock one data bit into the shift byte
      if (do_bit) begin
         bit_byte = bit_one ? (shift_ff | wmask_ff) : (shift_ff & ~wmask_ff);
         shift_in = bit_byte;
         if (wmask_ff == EE_MASK_LAST) begin
            if (read_mode_ff) begin
               we = 1'b1;
            end else begin
               address_in = bit_byte[ROM_ADDR_W-1:0];
            end
            wmask_in = '0;
         end else begin
            wmask_in = wmask_ff << 1;
         end
         rmask_in = '0;
      end
   end

   // state registers and per-entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= 1'b0;
         read_mode_ff <= 1'b0;
         address_ff   <= '0;
         shift_ff     <= '0;
         wmask_ff     <= '0;
         rmask_ff     <= '0;
         hist_ff      <= '{default: '0};
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         status_ff    <= status_in;
         read_mode_ff <= read_mode_in;
         address_ff   <= address_in;
         shift_ff     <= shift_in;
         wmask_ff     <= wmask_in;
         rmask_ff     <= rmask_in;
         hist_ff      <= hist_in;
         fwd_valid_ff <= we;
         if (we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // forwarded write data
   always_ff @(posedge clock) begin
      fwd_data_ff <= bit_byte;
   end

   rbm_ram #(
      .WIDTH (8),
      .DEPTH (EEPROM_BYTES)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (wr_addr),
      .wdata (bit_byte),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign status_bit = status_ff;

endmodule

[hw/rtl/rbm_irq.sv]
// 16-bit irq down counter with reload latch
module rbm_irq import rbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  irq_ctl_type ctl,
   output logic        irq_fire
);

   logic        on_ff, on_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] reload_ff, reload_in;
   logic [15:0] amount;

   assign amount   = 16'(ctl.amount);
   assign irq_fire = ctl.tick && on_ff && (count_ff <= amount);

   // latch writes, arming and counting
   always_comb begin
      on_in     = on_ff;
      count_in  = count_ff;
      reload_in = reload_ff;
      if (ctl.ctrl_wr) begin
         on_in    = ctl.data[0];
         count_in = reload_ff;
      end
      if (ctl.lo_wr) begin
         reload_in[7:0] = ctl.data;
      end
      if (ctl.hi_wr) begin
         reload_in[15:8] = ctl.data;
      end
      if (ctl.tick && on_ff) begin
         if (irq_fire) begin
            on_in    = 1'b0;
            count_in = '0;
         end else begin
            count_in = count_ff - amount;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff     <= 1'b0;
         count_ff  <= '0;
         reload_ff <= '0;
      end else begin
         on_ff     <= on_in;
         count_ff  <= count_in;
         reload_ff <= reload_in;
      end
   end

endmodule

[hw/rtl/rom_bank_mapper_irq_serial_eeprom_unit.sv]
// Cartridge bank mapper top level. A request word is captured in an input register at the edge
// that accepts it and is decoded once the result buffer is free; its response words are then
// registered into the buffer and offered from there. A word can be accepted every cycle while
// the decode is not held by a busy buffer. A word yields zero to four response words, which sit
// in a four-entry result buffer and leave at one per cycle while rsp_ready is high; the next
// request is decoded as soon as the buffer drains to its final entry being taken. The eeprom
// store keeps one valid bit per byte, so it reads as zero after reset with no clearing pass. The
// csr port (3 registers at byte addresses 0, 4, 8) is always ready.
module rom_bank_mapper_irq_serial_eeprom_unit import rbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_wdata,
   input  logic [7:0]  req_cycle_count,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_slot,
   output logic [9:0]  rsp_value,
   output logic        rsp_last,
   // csr port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // csr registers
   logic alt_mode_ff, scanline_ff, chr_rom_ff;

   // input register
   logic        in_valid_ff;
   op_type      in_op_ff;
   logic [15:0] in_addr_ff;
   logic [7:0]  in_wdata_ff;
   logic [7:0]  in_cycles_ff;

   // alternate board bank registers
   logic       alt0_ff, alt0_in;
   logic       alt1_ff, alt1_in;
   logic [7:0] alt2_ff, alt2_in;

   // result buffer
   result_type buf_ff [MAX_RESULTS];
   logic [2:0] cnt_ff;

   logic        go;
   logic        buf_free;
   logic        load;
   result_type  res [MAX_RESULTS];
   logic [2:0]  res_n;
   ee_cmd_type  ee_cmd;
   irq_ctl_type irq_ctl;
   logic        irq_fire;
   logic        status_bit;
   logic [3:0]  reg_sel;
   logic [9:0]  lo_page;
   logic [9:0]  hi_page;
   logic        csr_wr;

   // csr access
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_mode_ff <= 1'b0;
         scanline_ff <= 1'b0;
         chr_rom_ff  <= 1'b1;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            CSR_ALT_MODE: alt_mode_ff <= pwdata[0];
            CSR_SCANLINE: scanline_ff <= pwdata[0];
            CSR_CHR_ROM:  chr_rom_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_ALT_MODE: prdata = {31'b0, alt_mode_ff};
         CSR_SCANLINE: prdata = {31'b0, scanline_ff};
         CSR_CHR_ROM:  prdata = {31'b0, chr_rom_ff};
         default:      prdata = '0;
      endcase
   end

   // handshake: decode when the buffer is empty or handing out its final word
   assign buf_free  = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_ready);
   assign go        = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || go;
   assign load      = go && (res_n != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff     <= op_type'(req_op);
         in_addr_ff   <= req_addr;
         in_wdata_ff  <= req_wdata;
         in_cycles_ff <= req_cycle_count;
      end
   end

   assign reg_sel = in_addr_ff[3:0];
   assign lo_page = {4'b0, alt0_in, 5'b0} + {1'b0, alt2_in, 1'b0};
   assign hi_page = {4'b0, alt1_in, 5'b0};

   // word decode
   always_comb begin
      res     = '{default: '0};
      res_n   = 3'd0;
      ee_cmd  = '0;
      irq_ctl = '0;
      alt0_in = alt0_ff;
      alt1_in = alt1_ff;
      alt2_in = alt2_ff;
      irq_ctl.data = in_wdata_ff;
      ee_cmd.data  = in_wdata_ff;
      unique case (in_op_ff)
         OP_WRITE: begin
            if (!alt_mode_ff) begin
               unique case (reg_sel) inside
                  [REG_CHR_FIRST:REG_CHR_LAST]: begin
                     if (chr_rom_ff) begin
                        res[0] = '{KIND_CHR, reg_sel[2:0], {2'b0, in_wdata_ff}};
                        res_n  = 3'd1;
                     end
                  end
                  REG_PRG: begin
                     res[0] = '{KIND_PRG16, SLOT_PRG16, {2'b0, in_wdata_ff}};
                     res_n  = 3'd1;
                  end
                  REG_EEPROM: ee_cmd.wr_en = go;
                  REG_MIRROR: begin
                     res[0] = '{KIND_MIRROR, SLOT_NONE, {8'b0, in_wdata_ff[1:0]}};
                     res_n  = 3'd1;
                  end
                  REG_IRQ_CTRL: irq_ctl.ctrl_wr = go;
                  REG_IRQ_LO:   irq_ctl.lo_wr   = go;
                  REG_IRQ_HI:   irq_ctl.hi_wr   = go;
                  default: ;
               endcase
            end else if (in_addr_ff < HIGH_REGION_BASE) begin
               res[0] = '{KIND_PASS, SLOT_NONE, {2'b0, in_wdata_ff}};
               res_n  = 3'd1;
            end else if (in_addr_ff <= ALT_REG_END) begin
               unique case (reg_sel) inside
                  [REG_CHR_FIRST:REG_ALT_LO_LAST]: begin
                     alt0_in = in_wdata_ff[0];
                     res[0]  = '{KIND_PRG8, SLOT_PRG8_0, lo_page};
                     res[1]  = '{KIND_PRG8, SLOT_PRG8_1, lo_page + 10'd1};
                     res_n   = 3'd2;
                  end
                  [REG_ALT_LO_LAST+4'd1:REG_CHR_LAST]: begin
                     alt1_in = in_wdata_ff[0];
                     res[0]  = '{KIND_PRG8, SLOT_PRG8_2, hi_page + ALT_HI_PAGE0};
                     res[1]  = '{KIND_PRG8, SLOT_PRG8_3, hi_page + ALT_HI_PAGE1};
                     res_n   = 3'd2;
                  end
                  REG_PRG: begin
                     alt2_in = in_wdata_ff;
                     res[0]  = '{KIND_PRG8, SLOT_PRG8_0, lo_page};
                     res[1]  = '{KIND_PRG8, SLOT_PRG8_1, lo_page + 10'd1};
                     res[2]  = '{KIND_PRG8, SLOT_PRG8_2, hi_page + ALT_HI_PAGE0};
                     res[3]  = '{KIND_PRG8, SLOT_PRG8_3, hi_page + ALT_HI_PAGE1};
                     res_n   = 3'd4;
                  end
                  REG_MIRROR: begin
                     res[0] = '{KIND_MIRROR, SLOT_NONE, {8'b0, in_wdata_ff[1:0]}};
                     res_n  = 3'd1;
                  end
                  REG_IRQ_CTRL: irq_ctl.ctrl_wr = go;
                  REG_IRQ_LO:   irq_ctl.lo_wr   = go;
                  REG_IRQ_HI:   irq_ctl.hi_wr   = go;
                  default: ;
               endcase
            end
         end
         OP_READ: begin
            if (in_addr_ff >= HIGH_REGION_BASE || alt_mode_ff) begin
               res[0] = '{KIND_PASS, SLOT_NONE, 10'd0};
            end else if (in_addr_ff[7:0] == 8'h00 && status_bit) begin
               res[0] = '{KIND_READ, SLOT_NONE, READ_STATUS};
            end else begin
               res[0] = '{KIND_READ, SLOT_NONE, 10'd0};
            end
            res_n = 3'd1;
         end
         OP_CYCLES: begin
            irq_ctl.tick   = go && !scanline_ff;
            irq_ctl.amount = in_cycles_ff;
            if (irq_fire) begin
               res[0] = '{KIND_IRQ, SLOT_NONE, 10'd0};
               res_n  = 3'd1;
            end
         end
         OP_SCANLINE: begin
            irq_ctl.tick   = go && scanline_ff;
            irq_ctl.amount = SCANLINE_CYCLES;
            if (irq_fire) begin
               res[0] = '{KIND_IRQ, SLOT_NONE, 10'd0};
               res_n  = 3'd1;
            end
         end
         default: ;
      endcase
   end

   // alternate bank registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alt0_ff <= 1'b0;
         alt1_ff <= 1'b0;
         alt2_ff <= '0;
      end else if (go) begin
         alt0_ff <= alt0_in;
         alt1_ff <= alt1_in;
         alt2_ff <= alt2_in;
      end
   end

   // result buffer, head word at entry 0
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (load) begin
         cnt_ff <= res_n;
      end else if (rsp_valid && rsp_ready) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= res;
      end else if (rsp_valid && rsp_ready) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
   end

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_kind  = buf_ff[0].kind;
   assign rsp_slot  = buf_ff[0].slot;
   assign rsp_value = buf_ff[0].value;
   assign rsp_last  = (cnt_ff == 3'd1);

   rbm_eeprom u_eeprom (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ee_cmd),
      .status_bit (status_bit)
   );

   rbm_irq u_irq (
      .clock    (clock),
      .reset    (reset),
      .ctl      (irq_ctl),
      .irq_fire (irq_fire)
   );

endmodule

[hw/rtl/rbm_checker.sv]
// port-level checks of the mapper top level, bound to it
`include "assert_macros.svh"

module rbm_checker import rbm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [2:0] rsp_slot,
   input logic [9:0] rsp_value,
   input logic       rsp_last
);

   // no response word right after reset
   `RBM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response word holds
   `RBM_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot)
         && $stable(rsp_value) && $stable(rsp_last), "stalled response word changed")

   // a word that is not last is followed by another
   `RBM_ASSERT(a_burst_cont, clock, reset,
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid, "result burst broken")

   // the first 8K page word of a pair is followed by its partner
   `RBM_ASSERT(a_prg8_pair, clock, reset,
      rsp_valid && rsp_ready && !rsp_last && rsp_kind == KIND_PRG8 && rsp_slot == SLOT_PRG8_0
         |=> rsp_valid && rsp_kind == KIND_PRG8 && rsp_slot == SLOT_PRG8_1,
      "8K page pair split")

   // requests are held off only while results wait
   `RBM_ASSERT(a_stall_cause, clock, reset, !req_ready |-> rsp_valid, "request stalled while idle")

endmodule

bind rom_bank_mapper_irq_serial_eeprom_unit rbm_checker u_checker (.*);

[tb/rom_bank_mapper_irq_serial_eeprom_unit_tb.sv]
// testbench for the rom bank mapper: directed and random bus words checked against a local model
`timescale 1ns / 100ps

module rom_bank_mapper_irq_serial_eeprom_unit_tb;
   import rbm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [9:0] ALT_PAGE_STRIDE = 10'h020;

   // one predicted response word
   typedef struct packed {
      kind_type   kind;
      logic [2:0] slot;
      logic [9:0] value;
      logic       last;
   } bank_event_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic [15:0] req_addr;
   logic [7:0]  req_wdata;
   logic [7:0]  req_cycle_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [2:0]  rsp_slot;
   logic [9:0]  rsp_value;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   rom_bank_mapper_irq_serial_eeprom_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op), .req_addr(req_addr),
      .req_wdata(req_wdata), .req_cycle_count(req_cycle_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind), .rsp_slot(rsp_slot),
      .rsp_value(rsp_value), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   // mapper model state, at its reset values
   bit         cfg_alt;
   bit         cfg_scanline;
   bit         cfg_chr_rom = 1'b1;
   bit         irq_armed;
   bit [15:0]  irq_cnt;
   bit [15:0]  irq_reload_val;
   bit         ee_status;
   bit         ee_read_mode;
   bit [6:0]   ee_addr;
   bit [7:0]   ee_shift;
   bit [7:0]   ee_wmask;
   bit [7:0]   ee_rmask;
   bit [7:0]   ee_hist [4];
   bit [7:0]   ee_mem [EEPROM_BYTES];
   bit [7:0]   alt_bank [3];

   bank_event_type bank_events [$];
   int          mismatches = 0;
   bit          req_gaps_on = 1'b0;
   bit          rsp_gaps_on = 1'b0;
   int          rsp_hold_cycles = 0;
   int          cycles_run = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic void post_event(kind_type k, logic [2:0] s, logic [9:0] v);
      bank_event_type ev;
      ev.kind = k;
      ev.slot = s;
      ev.value = v;
      ev.last = 1'b0;
      bank_events.push_back(ev);
   endfunction

   // clock one data bit into the serial shift byte
   function automatic void ee_shift_bit(bit one);
      if (one) ee_shift = ee_shift | ee_wmask;
      else ee_shift = ee_shift & ~ee_wmask;
      if (ee_wmask == EE_MASK_LAST) begin
         if (ee_read_mode) ee_mem[ee_addr] = ee_shift;
         else ee_addr = ee_shift[6:0];
         ee_wmask = 8'h00;
      end else begin
         ee_wmask = ee_wmask << 1;
      end
      ee_rmask = 8'h00;
   endfunction

   // line pattern on the eeprom register, matched against the last four
   function automatic void ee_line_write(bit [7:0] d);
      if (d == EE_RESET) begin
         ee_addr = 7'd0;
         ee_read_mode = 1'b0;
         ee_wmask = 8'h00;
         ee_rmask = 8'h00;
      end else if (ee_hist[3] == EE_NONE && ee_hist[2] == EE_SCL && ee_hist[1] == EE_BOTH &&
                   ee_hist[0] == EE_SDA && d == EE_NONE) begin
         // sync pattern, no effect
      end else if (ee_hist[3] == EE_NONE && ee_hist[2] == EE_SDA && ee_hist[1] == EE_BOTH &&
                   ee_hist[0] == EE_SCL && d == EE_NONE) begin
         ee_wmask = EE_MASK_FIRST;
         ee_rmask = EE_MASK_FIRST;
         ee_shift = 8'h00;
         ee_read_mode = 1'b0;
      end else if (ee_hist[0] == EE_BOTH && d == EE_READ) begin
         if (!ee_read_mode) begin
            ee_wmask = EE_MASK_FIRST;
            ee_rmask = EE_MASK_FIRST;
            ee_shift = 8'h00;
            ee_read_mode = 1'b1;
            ee_status = 1'b0;
         end else begin
            ee_shift = ee_mem[ee_addr];
            ee_status = |(ee_shift & ee_rmask);
            ee_rmask = ee_rmask << 1;
            ee_wmask = 8'h00;
         end
      end else if (ee_hist[1] == EE_NONE && ee_hist[0] == EE_SCL && d == EE_NONE) begin
         ee_shift_bit(1'b0);
      end else if (ee_hist[3] == EE_NONE && ee_hist[2] == EE_SDA && ee_hist[1] == EE_BOTH &&
                   ee_hist[0] == EE_SDA && d == EE_NONE) begin
         ee_shift_bit(1'b1);
      end
      ee_hist[3] = ee_hist[2];
      ee_hist[2] = ee_hist[1];
      ee_hist[1] = ee_hist[0];
      ee_hist[0] = d;
   endfunction

   // mirroring and irq registers, shared by both boards
   function automatic void shared_reg_write(logic [3:0] r, bit [7:0] d);
      case (r)
         REG_MIRROR: post_event(KIND_MIRROR, SLOT_NONE, 10'(d[1:0]));
         REG_IRQ_CTRL: begin
            irq_armed = d[0];
            irq_cnt = irq_reload_val;
         end
         REG_IRQ_LO: irq_reload_val[7:0] = d;
         REG_IRQ_HI: irq_reload_val[15:8] = d;
         default: ;
      endcase
   endfunction

   // lower 16k of the alternate board, two 8k pages
   function automatic void alt_low_pages();
      logic [9:0] page;
      page = 10'(alt_bank[0]) * ALT_PAGE_STRIDE + 10'(alt_bank[2]) * 10'd2;
      post_event(KIND_PRG8, SLOT_PRG8_0, page);
      post_event(KIND_PRG8, SLOT_PRG8_1, page + 10'd1);
   endfunction

   function automatic void alt_high_pages();
      logic [9:0] page;
      page = 10'(alt_bank[1]) * ALT_PAGE_STRIDE;
      post_event(KIND_PRG8, SLOT_PRG8_2, page + ALT_HI_PAGE0);
      post_event(KIND_PRG8, SLOT_PRG8_3, page + ALT_HI_PAGE1);
   endfunction

   // bank updates caused by one accepted bus word
   function automatic void decode_bus_word(op_type op, logic [15:0] addr, bit [7:0] d,
                                           bit [7:0] cyc);
      int             depth0;
      logic [3:0]     r;
      bank_event_type tail_ev;
      depth0 = bank_events.size();
      r = addr[3:0];
      case (op)
         OP_WRITE: begin
            if (!cfg_alt) begin
               if (r <= REG_CHR_LAST) begin
                  if (cfg_chr_rom) post_event(KIND_CHR, r[2:0], 10'(d));
               end else if (r == REG_PRG) begin
                  post_event(KIND_PRG16, SLOT_PRG16, 10'(d));
               end else if (r == REG_EEPROM) begin
                  ee_line_write(d);
               end else begin
                  shared_reg_write(r, d);
               end
            end else if (addr < HIGH_REGION_BASE) begin
               post_event(KIND_PASS, SLOT_NONE, 10'(d));
            end else if (addr <= ALT_REG_END) begin
               if (r <= REG_ALT_LO_LAST) begin
                  alt_bank[0] = {7'd0, d[0]};
                  alt_low_pages();
               end else if (r <= REG_CHR_LAST) begin
                  alt_bank[1] = {7'd0, d[0]};
                  alt_high_pages();
               end else if (r == REG_PRG) begin
                  alt_bank[2] = d;
                  alt_low_pages();
                  alt_high_pages();
               end else begin
                  shared_reg_write(r, d);
               end
            end
         end
         OP_READ: begin
            if (addr >= HIGH_REGION_BASE || cfg_alt) begin
               post_event(KIND_PASS, SLOT_NONE, 10'd0);
            end else begin
               post_event(KIND_READ, SLOT_NONE,
                          (addr[7:0] == 8'h00 && ee_status) ? READ_STATUS : 10'd0);
            end
         end
         OP_CYCLES: begin
            if (!cfg_scanline && irq_armed) begin
               if (irq_cnt <= 16'(cyc)) begin
                  irq_armed = 1'b0;
                  irq_cnt = 16'd0;
                  post_event(KIND_IRQ, SLOT_NONE, 10'd0);
               end else begin
                  irq_cnt = irq_cnt - 16'(cyc);
               end
            end
         end
         default: begin
            if (cfg_scanline && irq_armed) begin
               if (irq_cnt <= 16'(SCANLINE_CYCLES)) begin
                  irq_armed = 1'b0;
                  irq_cnt = 16'd0;
                  post_event(KIND_IRQ, SLOT_NONE, 10'd0);
               end else begin
                  irq_cnt = irq_cnt - 16'(SCANLINE_CYCLES);
               end
            end
         end
      endcase
      // flag the final word of this input
      if (bank_events.size() > depth0) begin
         tail_ev = bank_events.pop_back();
         tail_ev.last = 1'b1;
         bank_events.push_back(tail_ev);
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // every driver task starts and ends just after a falling edge
   task automatic send_word(input op_type op, input logic [15:0] addr, input logic [7:0] d,
                            input logic [7:0] cyc);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_addr <= addr;
      req_wdata <= d;
      req_cycle_count <= cyc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_bus_word(op, addr, d, cyc);
      @(negedge clock);
   endtask

   // stop sending and let every pending word come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (bank_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // apb write with a read back, only while the mapper is idle
   task automatic csr_write(input logic [1:0] idx, input bit v);
      logic [31:0] got;
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {31'd0, v};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         CSR_ALT_MODE: cfg_alt = v;
         CSR_SCANLINE: cfg_scanline = v;
         CSR_CHR_ROM: cfg_chr_rom = v;
         default: ;
      endcase
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== {31'd0, v}) begin
         mismatches++;
         $error("csr %0d read back: expected %0h, got %0h", idx, v, got);
      end
   endtask

   task automatic ee_line(input logic [7:0] d);
      send_word(OP_WRITE, {12'($urandom), REG_EEPROM}, d, 8'($urandom));
   endtask

   task automatic ee_start();
      ee_line(EE_NONE);
      ee_line(EE_SDA);
      ee_line(EE_BOTH);
      ee_line(EE_SCL);
      ee_line(EE_NONE);
   endtask

   // eight serial bits, lsb first
   task automatic ee_byte(input logic [7:0] v);
      for (int i = 0; i < 8; i++) begin
         if (v[i]) begin
            ee_line(EE_NONE);
            ee_line(EE_SDA);
            ee_line(EE_BOTH);
            ee_line(EE_SDA);
            ee_line(EE_NONE);
         end else begin
            ee_line(EE_NONE);
            ee_line(EE_SCL);
            ee_line(EE_NONE);
         end
      end
   endtask

   // point the irq reload value at the given count and arm it
   task automatic arm_irq(input logic [15:0] count);
      send_word(OP_WRITE, 16'h800B, count[7:0], 8'($urandom));
      send_word(OP_WRITE, 16'h800C, count[15:8], 8'($urandom));
      send_word(OP_WRITE, 16'h800A, 8'h01, 8'($urandom));
   endtask

   task automatic send_random_word();
      op_type      op;
      logic [15:0] addr;
      logic [7:0]  d;
      logic [7:0]  cyc;
      int          pick;
      pick = $urandom_range(0, 99);
      addr = 16'($urandom);
      d = 8'($urandom);
      cyc = 8'($urandom);
      case ($urandom_range(0, 5))
         0: cyc = 8'h00;
         1: cyc = 8'hFF;
         default: ;
      endcase
      if (pick < 40) begin
         op = OP_WRITE;
         case ($urandom_range(0, 3))
            0: addr = {1'b0, addr[14:0]};
            1: addr = HIGH_REGION_BASE + 16'($urandom_range(0, 15));
            default: ;
         endcase
         // eeprom writes mostly carry line patterns
         if (addr[3:0] == REG_EEPROM && $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
               0: d = EE_NONE;
               1: d = EE_SCL;
               2: d = EE_SDA;
               3: d = EE_BOTH;
               4: d = EE_RESET;
               default: d = EE_READ;
            endcase
         end
         // keep irq reload values short enough to expire
         if (addr[3:0] == REG_IRQ_HI && $urandom_range(0, 3) != 0) d = 8'h00;
      end else if (pick < 60) begin
         op = OP_READ;
         if ($urandom_range(0, 2) == 0) addr = {1'b0, addr[14:8], 8'h00};
      end else if (pick < 85) begin
         op = OP_CYCLES;
      end else begin
         op = OP_SCANLINE;
      end
      send_word(op, addr, d, cyc);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_bank_writes();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      for (int s = 0; s < 8; s++)
         send_word(OP_WRITE, {12'($urandom), 4'(s)}, (s % 2) ? 8'hFF : 8'h00, 8'($urandom));
      send_word(OP_WRITE, 16'hFFF8, 8'hFF, 8'hFF);
      send_word(OP_WRITE, 16'h0008, 8'h00, 8'h00);
      send_word(OP_WRITE, 16'h8009, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h7FF9, 8'h01, 8'h00);
      send_word(OP_WRITE, 16'h800E, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h000F, 8'hA5, 8'h00);
      send_word(OP_READ, 16'h0000, 8'h00, 8'h00);
      send_word(OP_READ, 16'h7F01, 8'h00, 8'h00);
      send_word(OP_READ, 16'h8000, 8'hFF, 8'hFF);
      send_word(OP_READ, 16'hFFFF, 8'h00, 8'h00);
   endtask

   task automatic test_chr_absent();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      csr_write(CSR_CHR_ROM, 1'b0);
      send_word(OP_WRITE, 16'h0000, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h8007, 8'h5A, 8'h00);
      send_word(OP_WRITE, 16'h8008, 8'h3C, 8'h00);
      send_word(OP_WRITE, 16'h8009, 8'h02, 8'h00);
      csr_write(CSR_CHR_ROM, 1'b1);
      send_word(OP_WRITE, 16'h8003, 8'hC3, 8'h00);
   endtask

   task automatic test_irq_counter();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      // zero count expires on a zero-cycle tick
      arm_irq(16'h0000);
      send_word(OP_CYCLES, 16'h0000, 8'h00, 8'h00);
      send_word(OP_CYCLES, 16'h0000, 8'h00, 8'hFF);
      // count down to one, then expire
      arm_irq(16'h0100);
      send_word(OP_SCANLINE, 16'h0000, 8'h00, 8'h00);
      send_word(OP_CYCLES, 16'h0000, 8'h00, 8'hFF);
      send_word(OP_CYCLES, 16'h0000, 8'h00, 8'h00);
      send_word(OP_CYCLES, 16'h0000, 8'h00, 8'h01);
      // long count, then disarmed
      send_word(OP_WRITE, 16'h800B, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h800C, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h800A, 8'hFF, 8'h00);
      send_word(OP_CYCLES, 16'h0000, 8'h00, 8'hC8);
      send_word(OP_WRITE, 16'h800A, 8'h00, 8'h00);
      send_word(OP_CYCLES, 16'h0000, 8'h00, 8'hFF);
      // per-scanline counting
      csr_write(CSR_SCANLINE, 1'b1);
      arm_irq(16'd114);
      send_word(OP_SCANLINE, 16'h0000, 8'h00, 8'h00);
      send_word(OP_CYCLES, 16'h0000, 8'h00, 8'hFF);
      send_word(OP_SCANLINE, 16'h0000, 8'h00, 8'h00);
      arm_irq(16'd113);
      send_word(OP_SCANLINE, 16'h0000, 8'h00, 8'h00);
      csr_write(CSR_SCANLINE, 1'b0);
   endtask

   task automatic test_eeprom_rounds();
      logic [7:0] rom_ptr;
      logic [7:0] rom_byte;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      // sync pattern leaves the eeprom alone
      ee_line(EE_NONE);
      ee_line(EE_SCL);
      ee_line(EE_BOTH);
      ee_line(EE_SDA);
      ee_line(EE_NONE);
      send_word(OP_READ, 16'h6000, 8'h00, 8'h00);
      repeat (1) begin
         rom_ptr = 8'($urandom);
         rom_byte = 8'($urandom);
         // store one byte
         ee_line(EE_RESET);
         ee_start();
         ee_byte(rom_ptr);
         ee_line(EE_BOTH);
         ee_line(EE_READ);
         ee_byte(rom_byte);
         // read it back bit by bit through the status flag
         ee_start();
         ee_byte(rom_ptr);
         ee_line(EE_BOTH);
         ee_line(EE_READ);
         // the ninth read runs past the read mask
         repeat (9) begin
            ee_line(EE_BOTH);
            ee_line(EE_READ);
            send_word(OP_READ, {1'b0, 7'($urandom), 8'h00}, 8'($urandom), 8'($urandom));
            send_word(OP_READ, {1'b0, 7'($urandom), 8'($urandom_range(1, 255))},
                      8'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic test_alt_board();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      csr_write(CSR_ALT_MODE, 1'b1);
      send_word(OP_WRITE, 16'h0000, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h7FFF, 8'h00, 8'h00);
      send_word(OP_READ, 16'h1234, 8'h00, 8'h00);
      send_word(OP_READ, 16'h8000, 8'h00, 8'h00);
      send_word(OP_WRITE, 16'h8000, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h8004, 8'h01, 8'h00);
      send_word(OP_WRITE, 16'h8008, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h8003, 8'h00, 8'h00);
      send_word(OP_WRITE, 16'h8007, 8'hFE, 8'h00);
      send_word(OP_WRITE, 16'h8009, 8'h02, 8'h00);
      send_word(OP_WRITE, 16'h800D, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'hFFFF, 8'hFF, 8'h00);
      send_word(OP_WRITE, 16'h8008, 8'h00, 8'h00);
   endtask

   task automatic test_backpressure();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      // hold the response side while four-word writes keep coming
      rsp_hold_cycles = 150;
      repeat (24) send_word(OP_WRITE, 16'h8008, 8'($urandom), 8'($urandom));
      wait_drained();
   endtask

   task automatic test_random_configs();
      for (int mode = 0; mode < 8; mode++) begin
         csr_write(CSR_ALT_MODE, mode[0]);
         csr_write(CSR_SCANLINE, mode[1]);
         csr_write(CSR_CHR_ROM, mode[2]);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         arm_irq(16'($urandom_range(0, 400)));
         repeat (22) send_random_word();
      end
   endtask

   task automatic test_quiet_tail();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      csr_write(CSR_ALT_MODE, 1'b0);
      csr_write(CSR_SCANLINE, 1'b0);
      csr_write(CSR_CHR_ROM, 1'b1);
      repeat (40) send_random_word();
   endtask

   // ---------------------------------------------------------------- response side

   // ready with random stalls and commanded long holds
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each word taken against the oldest pending one
   always @(posedge clock) begin : check_words
      bank_event_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (bank_events.size() == 0) begin
            mismatches++;
            $error("word with nothing pending: kind=%0d slot=%0d value=%0d last=%0d",
                   rsp_kind, rsp_slot, rsp_value, rsp_last);
         end else begin
            want = bank_events.pop_front();
            if (rsp_kind !== want.kind) begin
               mismatches++;
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
            end
            if (rsp_slot !== want.slot) begin
               mismatches++;
               $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
            end
            if (rsp_value !== want.value) begin
               mismatches++;
               $error("value: expected %0d, got %0d", want.value, rsp_value);
            end
            if (rsp_last !== want.last) begin
               mismatches++;
               $error("last: expected %0d, got %0d", want.last, rsp_last);
            end
         end
      end
   end

   // run time limit
   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("rom_bank_mapper_irq_serial_eeprom_unit_tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_WRITE;
      req_addr = 16'h0000;
      req_wdata = 8'h00;
      req_cycle_count = 8'h00;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 4'h0;
      pwdata = 32'h0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_bank_writes();
      test_chr_absent();
      test_irq_counter();
      test_eeprom_rounds();
      test_alt_board();
      test_backpressure();
      test_random_configs();
      test_quiet_tail();
      wait_drained();
      if (mismatches == 0) begin
         $display("rom_bank_mapper_irq_serial_eeprom_unit_tb: done, clean");
      end else begin
         $display("rom_bank_mapper_irq_serial_eeprom_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

[rom_bank_mapper_irq_serial_eeprom_unit.f]
+incdir+hw/rtl
hw/rtl/rbm_pkg.sv
hw/rtl/rbm_ram.sv
hw/rtl/rbm_eeprom.sv
hw/rtl/rbm_irq.sv
hw/rtl/rom_bank_mapper_irq_serial_eeprom_unit.sv
hw/rtl/rbm_checker.sv
tb/rom_bank_mapper_irq_serial_eeprom_unit_tb.sv
